// ----- hdl/fss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types and constants of the frame slot selector.
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int POS_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int TIME_W       = 64;
    localparam int IDX_W        = 4;
    localparam int EXT_W        = POS_W + IDX_W;
    localparam int IN_TDATA_W   = 3 * TIME_W;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [POS_W-1:0]  POS_MAX   = POS_W'(WINDOW_DEPTH - 1);
    localparam logic [TIME_W-1:0] TIME_ONES = {TIME_W{1'b1}};

    localparam logic MODE_SMOOTH = 1'b0;
    localparam logic MODE_NEWEST = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] entry_time;
        logic [TIME_W-1:0] slot_time;
        logic [TIME_W-1:0] last_emitted_time;
        logic              last_entry;
    } beat_t;

    typedef struct packed {
        logic emit;
        logic [IDX_W-1:0] chosen_index;
        logic [IDX_W-1:0] dropped_count;
    } result_t;

endpackage
`default_nettype wire

// ----- hdl/fss_in_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fss_in_stage
// Input register: captures one beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module fss_in_stage
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [fss_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  wire                                 s_axis_tlast,
    output logic                                beat_valid,
    output fss_pkg::beat_t                      beat,
    input  wire                                 beat_take
);

    logic           valid_reg;
    logic           valid_next;
    fss_pkg::beat_t beat_reg;
    logic           accept;

    assign s_axis_tready = !valid_reg || beat_take;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (beat_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg.entry_time        <= s_axis_tdata[fss_pkg::TIME_W-1:0];
            beat_reg.slot_time         <= s_axis_tdata[2*fss_pkg::TIME_W-1:fss_pkg::TIME_W];
            beat_reg.last_emitted_time <= s_axis_tdata[3*fss_pkg::TIME_W-1:2*fss_pkg::TIME_W];
            beat_reg.last_entry        <= s_axis_tlast;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule
`default_nettype wire

// ----- hdl/fss_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fss_core
// Window state, nearest/newest selection and the result register.
// ----------------------------------------------------------------------------
module fss_core
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 pacing_mode,
    input  wire                                 beat_valid,
    input  fss_pkg::beat_t                      beat,
    output logic                                beat_take,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [fss_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic [fss_pkg::POS_W-1:0]  position_reg, position_next;
    logic                       fresh_seen_reg, fresh_seen_next;
    logic [fss_pkg::POS_W-1:0]  first_fresh_reg, first_fresh_next;
    logic [fss_pkg::TIME_W-1:0] best_dist_reg, best_dist_next;
    logic [fss_pkg::POS_W-1:0]  best_idx_reg, best_idx_next;
    logic                       out_valid_reg, out_valid_next;
    fss_pkg::result_t           result_reg, result_next;

    logic [fss_pkg::TIME_W-1:0] distance;
    logic                       fresh;
    logic [fss_pkg::POS_W-1:0]  chosen;
    logic [fss_pkg::EXT_W-1:0]  dropped_ext;

    assign beat_take = beat_valid && (!out_valid_reg || m_axis_tready);

    assign distance = (beat.entry_time >= beat.slot_time)
                    ? (beat.entry_time - beat.slot_time)
                    : (beat.slot_time - beat.entry_time);
    assign fresh    = beat.entry_time > beat.last_emitted_time;

    always_comb
    begin
        position_next    = position_reg;
        fresh_seen_next  = fresh_seen_reg;
        first_fresh_next = first_fresh_reg;
        best_dist_next   = best_dist_reg;
        best_idx_next    = best_idx_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        result_next      = result_reg;
        chosen           = '0;
        dropped_ext      = '0;

        if (beat_take)
        begin
            if (!fresh_seen_reg)
            begin
                if (fresh)
                begin
                    fresh_seen_next  = 1'b1;
                    first_fresh_next = position_reg;
                    best_idx_next    = position_reg;
                    best_dist_next   = distance;
                end
            end
            else if (distance < best_dist_reg)
            begin
                best_dist_next = distance;
                best_idx_next  = position_reg;
            end

            if (!beat.last_entry)
            begin
                if (position_reg != fss_pkg::POS_MAX)
                begin
                    position_next = position_reg + 1'b1;
                end
            end
            else
            begin
                chosen      = (pacing_mode == fss_pkg::MODE_NEWEST) ? position_reg
                                                                    : best_idx_next;
                dropped_ext = fss_pkg::EXT_W'(chosen) - fss_pkg::EXT_W'(first_fresh_next);
                out_valid_next = 1'b1;
                if (fresh_seen_next)
                begin
                    result_next.emit          = 1'b1;
                    result_next.chosen_index  = fss_pkg::IDX_W'(fss_pkg::EXT_W'(chosen));
                    result_next.dropped_count = dropped_ext[fss_pkg::IDX_W-1:0];
                end
                else
                begin
                    result_next = '0;
                end
                position_next    = '0;
                fresh_seen_next  = 1'b0;
                first_fresh_next = '0;
                best_dist_next   = fss_pkg::TIME_ONES;
                best_idx_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            fresh_seen_reg  <= 1'b0;
            first_fresh_reg <= '0;
            best_dist_reg   <= fss_pkg::TIME_ONES;
            best_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            position_reg    <= position_next;
            fresh_seen_reg  <= fresh_seen_next;
            first_fresh_reg <= first_fresh_next;
            best_dist_reg   <= best_dist_next;
            best_idx_reg    <= best_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        {(fss_pkg::OUT_TDATA_W - 1 - 2*fss_pkg::IDX_W){1'b0}},
        result_reg.dropped_count,
        result_reg.chosen_index,
        result_reg.emit
    };

endmodule
`default_nettype wire

// ----- hdl/frame_slot_selector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frame_slot_selector
// Picks which frame of a timestamp window fills an output slot.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one window entry per beat, oldest first; tlast marks the
//   final entry of a window. The slot time and the last emitted time ride
//   along with every entry.
//   m_axis carries one result beat per window, produced by the final entry:
//   emit, the chosen window position and the count of entries from the first fresh one to the chosen one.
//   cfg_we/cfg_wdata write pacing_mode (0 nearest to slot, 1 newest entry);
//   write it only while no window is in flight.
// Pipeline and throughput:
//   One beat per cycle while m_axis takes the results. A final entry's result
//   passes through the input register and then the result register, with
//   the 64-bit distance subtract and min compare between them.
// Reset:
//   rst_n clears the window state, drops any held beat and result, and sets
//   pacing_mode to nearest-to-slot.
// Stalls:
//   While a result waits on m_axis, the next entry may still enter the input
//   register; further entries wait until the result is taken.
// ----------------------------------------------------------------------------
module frame_slot_selector
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire                                 cfg_wdata,      // pacing_mode
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [63:0] entry_time, [127:64] slot_time, [191:128] last_emitted_time
    input  wire  [fss_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  wire                                 s_axis_tlast,   // last_entry
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [0] emit, [4:1] chosen_index, [8:5] dropped_count, [15:9] zero
    output logic [fss_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic           pacing_mode_reg;
    logic           beat_valid;
    logic           beat_take;
    fss_pkg::beat_t beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pacing_mode_reg <= fss_pkg::MODE_SMOOTH;
        end
        else if (cfg_we)
        begin
            pacing_mode_reg <= cfg_wdata;
        end
    end

    fss_in_stage u_in_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .beat_valid    (beat_valid),
        .beat          (beat),
        .beat_take     (beat_take)
    );

    fss_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pacing_mode   (pacing_mode_reg),
        .beat_valid    (beat_valid),
        .beat          (beat),
        .beat_take     (beat_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_slot_selector.
// Streams timestamp windows into s_axis and checks every result beat on
// m_axis against a cycle-free model of the window selection, or against the
// expected result written into some table rows. A short table of hand-built
// windows comes first; randomized windows follow in phases that alternate the
// pacing mode and the amount of idling on both sides.
module tb;

    localparam int IDLE_MAX       = 9;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 6;
    localparam int PHASE_ENTRIES  = 70;

    typedef struct {
        logic             mode;
        fss_pkg::beat_t   b;
        bit               typed;
        fss_pkg::result_t want;
    } dir_row_t;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic                            cfg_wdata     = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [fss_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tlast  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [fss_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // window selection model
    logic                       pacing_model    = fss_pkg::MODE_SMOOTH;
    logic [fss_pkg::POS_W-1:0]  win_pos         = '0;
    logic                       win_fresh       = 1'b0;
    logic [fss_pkg::POS_W-1:0]  win_first_fresh = '0;
    logic [fss_pkg::TIME_W-1:0] win_best_dist   = fss_pkg::TIME_ONES;
    logic [fss_pkg::POS_W-1:0]  win_best_idx    = '0;

    fss_pkg::result_t pending_picks[$];
    dir_row_t         dir_rows[$];

    int fail_cnt    = 0;
    int entry_cnt   = 0;
    int window_cnt  = 0;
    int emit_cnt    = 0;
    int sat_cnt     = 0;
    int longest     = 0;
    int quiet_cycles = 0;
    bit snd_idle    = 1'b1;
    bit rcv_idle    = 1'b1;
    bit hold_req    = 1'b0;

    frame_slot_selector DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [fss_pkg::TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic advance_window(input fss_pkg::beat_t b, output bit done,
                                  output fss_pkg::result_t pick);
        logic [fss_pkg::TIME_W-1:0] distance;
        logic [fss_pkg::POS_W-1:0]  sel;
        distance = (b.entry_time >= b.slot_time) ? b.entry_time - b.slot_time
                                                 : b.slot_time - b.entry_time;
        done = 1'b0;
        pick = '0;
        if (!win_fresh)
        begin
            if (b.entry_time > b.last_emitted_time)
            begin
                win_fresh       = 1'b1;
                win_first_fresh = win_pos;
                win_best_idx    = win_pos;
                win_best_dist   = distance;
            end
        end
        else if (distance < win_best_dist)
        begin
            win_best_dist = distance;
            win_best_idx  = win_pos;
        end
        if (!b.last_entry)
        begin
            if (win_pos < fss_pkg::POS_MAX)
                win_pos = win_pos + 1'b1;
        end
        else
        begin
            done = 1'b1;
            if (win_fresh)
            begin
                sel = (pacing_model == fss_pkg::MODE_NEWEST) ? win_pos : win_best_idx;
                pick.emit          = 1'b1;
                pick.chosen_index  = fss_pkg::IDX_W'(sel);
                pick.dropped_count = fss_pkg::IDX_W'(sel - win_first_fresh);
            end
            win_pos         = '0;
            win_fresh       = 1'b0;
            win_first_fresh = '0;
            win_best_dist   = fss_pkg::TIME_ONES;
            win_best_idx    = '0;
        end
    endtask

    task automatic offer_entry(input fss_pkg::beat_t b, input bit typed,
                               input fss_pkg::result_t want);
        int               gap;
        bit               done;
        fss_pkg::result_t pick;
        gap = snd_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.last_emitted_time, b.slot_time, b.entry_time};
        s_axis_tlast  <= b.last_entry;
        do @(posedge clk); while (!s_axis_tready);
        entry_cnt++;
        advance_window(b, done, pick);
        if (done)
        begin
            window_cnt++;
            if (pick.emit)
                emit_cnt++;
            pending_picks.push_back(typed ? want : pick);
        end
    endtask

    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_pacing(input logic mode);
        drain_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we       <= 1'b0;
        pacing_model = mode;
    endtask

    task automatic add_row(input logic mode,
                           input logic [fss_pkg::TIME_W-1:0] et, st, lt,
                           input logic tl, input bit typed,
                           input logic e, input logic [fss_pkg::IDX_W-1:0] ci, dc);
        dir_row_t r;
        r.mode                = mode;
        r.b.entry_time        = et;
        r.b.slot_time         = st;
        r.b.last_emitted_time = lt;
        r.b.last_entry        = tl;
        r.typed               = typed;
        r.want.emit           = e;
        r.want.chosen_index   = ci;
        r.want.dropped_count  = dc;
        dir_rows.push_back(r);
    endtask

    task automatic random_window(output int len);
        int                         pick;
        int                         kind;
        int                         step;
        int                         span;
        logic [fss_pkg::TIME_W-1:0] base;
        logic [fss_pkg::TIME_W-1:0] slot_t;
        logic [fss_pkg::TIME_W-1:0] last_t;
        fss_pkg::beat_t             b;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            len = $urandom_range(1, 5);
        else if (pick < 9)
            len = $urandom_range(6, 12);
        else
            len = $urandom_range(14, 20);
        kind = $urandom_range(0, 9);
        step = $urandom_range(1, 500);
        span = (len + 1) * step;
        case ($urandom_range(0, 7))
            0:       base = fss_pkg::TIME_ONES
                          - fss_pkg::TIME_W'($urandom_range(0, 3000));
            1:       base = fss_pkg::TIME_W'($urandom_range(0, 3000));
            default: base = rand64();
        endcase
        last_t = base - fss_pkg::TIME_W'(step)
               + fss_pkg::TIME_W'($urandom_range(0, span));
        slot_t = base - fss_pkg::TIME_W'(step)
               + fss_pkg::TIME_W'($urandom_range(0, span + step));
        if (kind == 6)
            last_t = base + fss_pkg::TIME_W'(span + step);     // mostly stale windows
        else if (kind == 9)
        begin
            last_t = rand64();
            slot_t = rand64();
        end
        for (int i = 0; i < len; i++)
        begin
            b.slot_time         = slot_t;
            b.last_emitted_time = last_t;
            if (kind < 7)
                b.entry_time = base
                             + fss_pkg::TIME_W'(i * step + $urandom_range(0, step / 2));
            else if (kind < 9)
                b.entry_time = base + fss_pkg::TIME_W'($urandom_range(0, span));
            else
            begin
                b.entry_time = rand64();
                if ($urandom_range(0, 1) == 1)
                    b.slot_time = rand64();
                if ($urandom_range(0, 3) == 0)
                    b.last_emitted_time = rand64();
            end
            b.last_entry = (i == len - 1);
            offer_entry(b, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : result_sink
        int               w;
        fss_pkg::result_t got;
        fss_pkg::result_t want;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                w = rcv_idle ? $urandom_range(0, IDLE_MAX) : 0;
                if (w > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (w) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got.emit          = m_axis_tdata[0];
            got.chosen_index  = m_axis_tdata[4:1];
            got.dropped_count = m_axis_tdata[8:5];
            if (pending_picks.size() == 0)
            begin
                $error("result beat with no window pending: tdata %h", m_axis_tdata);
                fail_cnt++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (got.emit !== want.emit)
                begin
                    $error("emit: expected %0d, got %0d", want.emit, got.emit);
                    fail_cnt++;
                end
                if (got.chosen_index !== want.chosen_index)
                begin
                    $error("chosen_index: expected %0d, got %0d",
                           want.chosen_index, got.chosen_index);
                    fail_cnt++;
                end
                if (got.dropped_count !== want.dropped_count)
                begin
                    $error("dropped_count: expected %0d, got %0d",
                           want.dropped_count, got.dropped_count);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int len;
        int n;
        // no fresh entry after reset, then extreme timestamps
        add_row(fss_pkg::MODE_SMOOTH, '0, '0, '0, 1'b1, 1'b1, 1'b0, 4'd0, 4'd0);
        add_row(fss_pkg::MODE_SMOOTH, fss_pkg::TIME_ONES, '0, fss_pkg::TIME_ONES - 1,
                1'b1, 1'b1, 1'b1, 4'd0, 4'd0);
        // nearest to slot in the middle
        add_row(fss_pkg::MODE_SMOOTH, 64'd10, 64'd19, 64'd5, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0);
        add_row(fss_pkg::MODE_SMOOTH, 64'd20, 64'd19, 64'd5, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0);
        add_row(fss_pkg::MODE_SMOOTH, 64'd30, 64'd19, 64'd5, 1'b1, 1'b0, 1'b0, 4'd0, 4'd0);
        // tie goes to the earlier entry
        add_row(fss_pkg::MODE_SMOOTH, 64'd10, 64'd20, 64'd0, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0);
        add_row(fss_pkg::MODE_SMOOTH, 64'd30, 64'd20, 64'd0, 1'b1, 1'b0, 1'b0, 4'd0, 4'd0);
        // stale entry after the first fresh one still competes
        add_row(fss_pkg::MODE_SMOOTH, 64'd50, 64'd95, 64'd100, 1'b0, 1'b0, 1'b0,
                4'd0, 4'd0);
        add_row(fss_pkg::MODE_SMOOTH, 64'd200, 64'd95, 64'd100, 1'b0, 1'b0, 1'b0,
                4'd0, 4'd0);
        add_row(fss_pkg::MODE_SMOOTH, 64'd90, 64'd95, 64'd100, 1'b1, 1'b0, 1'b0,
                4'd0, 4'd0);
        // full-range distance
        add_row(fss_pkg::MODE_SMOOTH, fss_pkg::TIME_ONES, '0, '0, 1'b0, 1'b0, 1'b0,
                4'd0, 4'd0);
        add_row(fss_pkg::MODE_SMOOTH, 64'd1, '0, '0, 1'b1, 1'b0, 1'b0, 4'd0, 4'd0);
        // newest mode, final entry stale or fresh
        add_row(fss_pkg::MODE_NEWEST, 64'd5, '0, 64'd4, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0);
        add_row(fss_pkg::MODE_NEWEST, 64'd1, '0, 64'd4, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0);
        add_row(fss_pkg::MODE_NEWEST, 64'd2, '0, 64'd4, 1'b1, 1'b0, 1'b0, 4'd0, 4'd0);
        add_row(fss_pkg::MODE_NEWEST, '0, fss_pkg::TIME_ONES, fss_pkg::TIME_ONES,
                1'b0, 1'b0, 1'b0, 4'd0, 4'd0);
        add_row(fss_pkg::MODE_NEWEST, 64'd7, fss_pkg::TIME_ONES, fss_pkg::TIME_ONES,
                1'b1, 1'b1, 1'b0, 4'd0, 4'd0);
        add_row(fss_pkg::MODE_NEWEST, 64'd1, '0, '0, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0);
        add_row(fss_pkg::MODE_NEWEST, 64'd8, '0, '0, 1'b1, 1'b0, 1'b0, 4'd0, 4'd0);
        add_row(fss_pkg::MODE_NEWEST, 64'd0, 64'd3, 64'd2, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0);
        add_row(fss_pkg::MODE_NEWEST, 64'd3, 64'd3, 64'd2, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0);
        add_row(fss_pkg::MODE_NEWEST, 64'd9, 64'd3, 64'd2, 1'b1, 1'b0, 1'b0, 4'd0, 4'd0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].mode != pacing_model)
                set_pacing(dir_rows[i].mode);
            offer_entry(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            snd_idle = (p % 3) != 2;
            rcv_idle = (p % 3) != 1;
            set_pacing((p % 2 == 0) ? fss_pkg::MODE_NEWEST : fss_pkg::MODE_SMOOTH);
            hold_req = (p == 3);
            n = 0;
            while (n < PHASE_ENTRIES)
            begin
                random_window(len);
                n += len;
                if (len > longest)
                    longest = len;
                if (len > fss_pkg::WINDOW_DEPTH)
                    sat_cnt++;
            end
        end
        drain_block();

        $display("Checked %0d windows (%0d emitting, %0d repeats) from %0d entries in both modes",
                 window_cnt, emit_cnt, window_cnt - emit_cnt, entry_cnt);
        $display("Longest window %0d entries, %0d windows past the depth, one long output hold",
                 longest, sat_cnt);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
